// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the token packet builder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// File: rtl/utpb_pkg.sv
// ----------------------------------------------------------------------------
// utpb_pkg
// types, constants and helper functions of the token packet builder
// ----------------------------------------------------------------------------
package utpb_pkg;

    localparam int PIPE_COUNT  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] PID_SOF_CODE   = 4'h5;
    localparam logic [3:0] PID_DATA0_CODE = 4'h3;
    localparam logic [3:0] PID_DATA1_CODE = 4'hB;

    localparam logic [4:0] CRC5_SEED = 5'h1F;
    localparam logic [4:0] CRC5_POLY = 5'h14;

    typedef enum logic [1:0] {
        FUNC_TOKEN     = 2'd0,
        FUNC_SOF       = 2'd1,
        FUNC_DATA      = 2'd2,
        FUNC_HANDSHAKE = 2'd3
    } t_func;

    // one classified request as it waits between front and back
    typedef struct packed {
        logic        three;     // pid byte plus two body bytes
        logic [7:0]  pid;
        logic [10:0] body;
        logic [4:0]  crc_part;  // crc register after the low six body bits
    } t_entry;

    function automatic logic [7:0] pid_byte(input logic [3:0] code);
        return {~code, code};
    endfunction

    function automatic logic [4:0] crc5_bit(input logic [4:0] x, input logic b);
        logic [4:0] sh;
        sh = {1'b0, x[4:1]};
        return (x[0] ^ b) ? (sh ^ CRC5_POLY) : sh;
    endfunction

    // first six bits of the crc5, lsb first, from the seed
    function automatic logic [4:0] crc5_lo(input logic [5:0] v);
        logic [4:0] x;
        x = CRC5_SEED;
        for (int i = 0; i < 6; i++) begin
            x = crc5_bit(x, v[i]);
        end
        return x;
    endfunction

    // remaining five bits and the final inversion
    function automatic logic [4:0] crc5_hi(input logic [4:0] x_in, input logic [4:0] v);
        logic [4:0] x;
        x = x_in;
        for (int i = 0; i < 5; i++) begin
            x = crc5_bit(x, v[i]);
        end
        return ~x;
    endfunction

endpackage

// File: rtl/utpb_front.sv
// ----------------------------------------------------------------------------
// utpb_front
// accepts requests, keeps the data toggles and classifies each request
// ----------------------------------------------------------------------------
module utpb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_func,
    input  logic [1:0]       i_pipe,
    input  logic [3:0]       i_pid_code,
    input  logic [6:0]       i_device_addr,
    input  logic [3:0]       i_endpoint_num,
    input  logic [10:0]      i_frame_num,
    output utpb_pkg::t_entry o_entry
);
    import utpb_pkg::*;

    logic [PIPE_COUNT-1:0] r_toggle;
    logic [PIPE_COUNT-1:0] n_toggle;
    logic [PIPE_COUNT-1:0] sel;
    logic                  tog;
    t_entry                entry;

    always_comb begin
        for (int i = 0; i < PIPE_COUNT; i++) begin
            sel[i] = (32'(i_pipe) == i);
        end
    end

    // pipes beyond the table read as data0
    assign tog = |(r_toggle & sel);

    always_comb begin
        n_toggle       = r_toggle;
        entry.three    = 1'b1;
        entry.pid      = pid_byte(i_pid_code);
        entry.body     = {i_endpoint_num, i_device_addr};
        unique case (t_func'(i_func))
            FUNC_TOKEN: begin
                if (i_accept) begin
                    if (i_pid_code == PID_DATA0_CODE || i_pid_code == PID_DATA1_CODE) begin
                        n_toggle = r_toggle ^ sel;
                    end else begin
                        n_toggle = r_toggle & ~sel;
                    end
                end
            end
            FUNC_SOF: begin
                entry.pid  = pid_byte(PID_SOF_CODE);
                entry.body = i_frame_num;
            end
            FUNC_DATA: begin
                entry.three = 1'b0;
                entry.pid   = tog ? pid_byte(PID_DATA1_CODE) : pid_byte(PID_DATA0_CODE);
                if (i_accept) begin
                    n_toggle = r_toggle ^ sel;
                end
            end
            default: begin
                entry.three = 1'b0;
            end
        endcase
        entry.crc_part = crc5_lo(entry.body[5:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle <= '0;
        end else begin
            r_toggle <= n_toggle;
        end
    end

    assign o_entry = entry;

endmodule

// File: rtl/utpb_queue.sv
// ----------------------------------------------------------------------------
// utpb_queue
// short queue of classified requests between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utpb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  utpb_pkg::t_entry i_entry,
    input  logic             i_rd,
    output utpb_pkg::t_entry o_head,
    output logic             o_full,
    output logic             o_empty
);
    import utpb_pkg::*;

    t_entry              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                wr_en;
    logic                rd_en;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_head  = r_slot[r_rptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (rd_en) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_CLK(a_ptr_track, i_clk, i_rst_n, (o_empty || o_full) |-> (r_wptr == r_rptr), "queue pointers out of step")

endmodule

// File: rtl/utpb_back.sv
// ----------------------------------------------------------------------------
// utpb_back
// finishes the crc and serializes each header into byte beats
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utpb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  utpb_pkg::t_entry i_head,
    input  logic             i_q_empty,
    output logic             o_q_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_packet_byte,
    output logic             o_last_byte
);
    import utpb_pkg::*;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_out_last,  n_out_last;
    logic        r_busy,      n_busy;
    logic        r_hi,        n_hi;
    logic [15:0] r_v,         n_v;
    logic        advance;

    assign advance = !r_out_valid || i_pop;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_busy      = r_busy;
        n_hi        = r_hi;
        n_v         = r_v;
        o_q_rd      = 1'b0;
        if (advance) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_out_byte  = r_hi ? r_v[15:8] : r_v[7:0];
                n_out_last  = r_hi;
                n_hi        = !r_hi;
                n_busy      = !r_hi;
            end else if (!i_q_empty) begin
                o_q_rd      = 1'b1;
                n_out_valid = 1'b1;
                n_out_byte  = i_head.pid;
                n_out_last  = !i_head.three;
                n_busy      = i_head.three;
                n_hi        = 1'b0;
                n_v         = {crc5_hi(i_head.crc_part, i_head.body[10:6]), i_head.body};
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_busy      <= 1'b0;
            r_hi        <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            r_busy      <= n_busy;
            r_hi        <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_v        <= n_v;
    end

    assign o_empty       = !r_out_valid;
    assign o_packet_byte = r_out_byte;
    assign o_last_byte   = r_out_last;

    `ASSERT_CLK(a_busy_mid, i_clk, i_rst_n, r_busy |-> (r_out_valid && !r_out_last), "body pending without open beat")
    `ASSERT_CLK(a_mid_busy, i_clk, i_rst_n, (r_out_valid && !r_out_last) |-> r_busy, "packet cut short")

endmodule

// File: rtl/usb_token_packet_builder_top.sv
// ----------------------------------------------------------------------------
// usb_token_packet_builder_top
// usb host packet header builder: token, sof, data pid and handshake
// ----------------------------------------------------------------------------
// Each request becomes one to three byte beats on the result side, in wire
// order, with o_last_byte set on the final beat: token and sof give three
// beats (pid, then the 11-bit field with its crc5, low byte first), data and
// handshake give the pid byte alone. A new request is taken in any cycle the
// two-entry queue has room, so requests arrive back to back; the result side
// sustains one beat per cycle when pop is held high. The byte-wide output
// register sets that figure. Through an empty queue, an accepted request is
// registered in a queue slot and then in the output register before its first
// beat shows. Data toggles reset to data0 for all pipes.
module usb_token_packet_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_func,
    input  logic [1:0]  i_pipe,
    input  logic [3:0]  i_pid_code,
    input  logic [6:0]  i_device_addr,
    input  logic [3:0]  i_endpoint_num,
    input  logic [10:0] i_frame_num,
    // byte side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_packet_byte,
    output logic        o_last_byte
);
    import utpb_pkg::*;

    t_entry front_entry;
    t_entry q_head;
    logic   accept;
    logic   q_empty;
    logic   q_rd;

    // a request beat lands when the queue has room
    assign accept = push && !full;

    // classify and update toggles at accept time
    utpb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_func         (i_func),
        .i_pipe         (i_pipe),
        .i_pid_code     (i_pid_code),
        .i_device_addr  (i_device_addr),
        .i_endpoint_num (i_endpoint_num),
        .i_frame_num    (i_frame_num),
        .o_entry        (front_entry)
    );

    // decouples request intake from byte serialization
    utpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_entry (front_entry),
        .i_rd    (q_rd),
        .o_head  (q_head),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // crc completion and byte beats
    utpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_q_empty     (q_empty),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_packet_byte (o_packet_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

// File: dv/usb_token_packet_builder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_token_packet_builder_top_tb
// self-checking bench for the usb token packet builder: requests go in as
// push beats, every byte beat that comes out is checked against a predicted
// stream kept by a small scoreboard with its own copy of the data toggles
// ----------------------------------------------------------------------------
module usb_token_packet_builder_top_tb;

    import utpb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 310;

    typedef struct {
        logic [7:0] pkt_byte;
        logic       last;
    } t_beat;

    // predicts the byte stream and compares what the block hands out
    class header_byte_tracker;
        t_beat      pending_bytes[$];
        logic       toggle_copy[PIPE_COUNT];
        int         errors;
        int         reported;

        function new();
            errors   = 0;
            reported = 0;
            for (int p = 0; p < PIPE_COUNT; p++) begin
                toggle_copy[p] = 1'b0;
            end
        endfunction

        function logic [7:0] pid_with_check(input logic [3:0] code);
            return {code ^ 4'hF, code};
        endfunction

        // usb crc5, lsb first, seed all ones, inverted at the end
        function logic [4:0] crc5_of_field(input logic [10:0] v);
            logic [4:0] x;
            x = 5'h1F;
            for (int i = 0; i < 11; i++) begin
                if (x[0] ^ v[i]) begin
                    x = {1'b0, x[4:1]} ^ 5'h14;
                end else begin
                    x = {1'b0, x[4:1]};
                end
            end
            return ~x;
        endfunction

        function void push_beat(input logic [7:0] b, input logic last);
            t_beat bt;
            bt.pkt_byte = b;
            bt.last     = last;
            pending_bytes.push_back(bt);
        endfunction

        function void push_three(input logic [7:0] pid, input logic [10:0] body);
            logic [15:0] word;
            word = {crc5_of_field(body), body};
            push_beat(pid, 1'b0);
            push_beat(word[7:0], 1'b0);
            push_beat(word[15:8], 1'b1);
        endfunction

        function void take_request(input t_func func, input logic [1:0] pipe,
                                   input logic [3:0] code, input logic [6:0] dev,
                                   input logic [3:0] ep, input logic [10:0] frame);
            logic in_range;
            logic tog;
            in_range = (int'(pipe) < PIPE_COUNT);
            tog      = in_range ? toggle_copy[pipe] : 1'b0;
            case (func)
                FUNC_TOKEN: begin
                    if (in_range) begin
                        if (code == PID_DATA0_CODE || code == PID_DATA1_CODE) begin
                            toggle_copy[pipe] = ~tog;
                        end else begin
                            toggle_copy[pipe] = 1'b0;
                        end
                    end
                    push_three(pid_with_check(code), {ep, dev});
                end
                FUNC_SOF: begin
                    push_three(pid_with_check(PID_SOF_CODE), frame);
                end
                FUNC_DATA: begin
                    push_beat(pid_with_check(tog ? PID_DATA1_CODE : PID_DATA0_CODE), 1'b1);
                    if (in_range) begin
                        toggle_copy[pipe] = ~tog;
                    end
                end
                default: begin
                    push_beat(pid_with_check(code), 1'b1);
                end
            endcase
        endfunction

        function void check_beat(input logic [7:0] b, input logic last);
            t_beat want;
            if (pending_bytes.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected beat: byte %02h last %0d", b, last);
                end
                return;
            end
            want = pending_bytes.pop_front();
            if (b !== want.pkt_byte || last !== want.last) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("beat mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                             want.pkt_byte, want.last, b, last);
                end
            end
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_func;
    logic [1:0]  i_pipe;
    logic [3:0]  i_pid_code;
    logic [6:0]  i_device_addr;
    logic [3:0]  i_endpoint_num;
    logic [10:0] i_frame_num;
    logic        empty;
    logic        pop;
    logic [7:0]  o_packet_byte;
    logic        o_last_byte;

    header_byte_tracker board;

    // idle odds in percent, changed per phase
    int tx_idle_pct;
    int rx_idle_pct;
    // long receiver hold-off, driven from its own process
    logic rx_hold;
    int   n_sent;

    usb_token_packet_builder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_pipe         (i_pipe),
        .i_pid_code     (i_pid_code),
        .i_device_addr  (i_device_addr),
        .i_endpoint_num (i_endpoint_num),
        .i_frame_num    (i_frame_num),
        .empty          (empty),
        .pop            (pop),
        .o_packet_byte  (o_packet_byte),
        .o_last_byte    (o_last_byte)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one request, with random idle cycles in front, and hold it until
    // the block takes it; everything is sampled right at the rising edge so
    // the values seen are the ones the block saw
    task automatic send_request(input t_func func, input logic [1:0] pipe,
                                input logic [3:0] code, input logic [6:0] dev,
                                input logic [3:0] ep, input logic [10:0] frame);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_func         <= func;
        i_pipe         <= pipe;
        i_pid_code     <= code;
        i_device_addr  <= dev;
        i_endpoint_num <= ep;
        i_frame_num    <= frame;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        // beat taken at this edge
        board.take_request(func, pipe, code, dev, ep, frame);
        n_sent++;
    endtask

    // random request; tokens lean toward the data pid codes so the toggles
    // really walk instead of being cleared every time
    task automatic send_random();
        t_func      func;
        logic [3:0] code;
        func = t_func'($urandom_range(3));
        code = 4'($urandom_range(15));
        if (func == FUNC_TOKEN && $urandom_range(2) == 0) begin
            code = $urandom_range(1) ? PID_DATA1_CODE : PID_DATA0_CODE;
        end
        send_request(func, 2'($urandom_range(3)), code, 7'($urandom_range(127)),
                     4'($urandom_range(15)), 11'($urandom_range(2047)));
    endtask

    // result side: pop at random, never while the hold-off is on
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                board.check_beat(o_packet_byte, o_last_byte);
            end
            pop <= i_rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one long stall of the receiver early in the run, so the queue fills
    // and full pushes back on the sender
    initial begin
        rx_hold = 1'b0;
        wait (n_sent >= 40);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // watchdog: cycles in a row with no beat on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || !i_rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("usb_token_packet_builder_top_tb NOT OK");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        board          = new();
        n_sent         = 0;
        tx_idle_pct    = 30;
        rx_idle_pct    = 72;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_func         = FUNC_TOKEN;
        i_pipe         = '0;
        i_pid_code     = '0;
        i_device_addr  = '0;
        i_endpoint_num = '0;
        i_frame_num    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every kind, toggle flips and clears
        send_request(FUNC_TOKEN, 2'd0, 4'h0, 7'd0, 4'd0, 11'd0);
        send_request(FUNC_TOKEN, 2'd3, 4'hF, 7'd127, 4'd15, 11'd2047);
        send_request(FUNC_TOKEN, 2'd1, 4'h9, 7'h55, 4'hA, 11'd0);
        send_request(FUNC_SOF, 2'd0, 4'h0, 7'd0, 4'd0, 11'd0);
        send_request(FUNC_SOF, 2'd2, 4'hF, 7'd127, 4'd15, 11'd2047);
        send_request(FUNC_SOF, 2'd1, 4'h0, 7'd0, 4'd0, 11'h555);
        // data on a fresh pipe gives data0, then data1
        send_request(FUNC_DATA, 2'd0, 4'h0, 7'd0, 4'd0, 11'd0);
        send_request(FUNC_DATA, 2'd0, 4'hF, 7'd127, 4'd15, 11'd2047);
        send_request(FUNC_DATA, 2'd3, 4'h5, 7'd0, 4'd0, 11'd0);
        // token with a data0 or data1 code flips the toggle
        send_request(FUNC_TOKEN, 2'd3, PID_DATA0_CODE, 7'd1, 4'd1, 11'd0);
        send_request(FUNC_DATA, 2'd3, 4'h0, 7'd0, 4'd0, 11'd0);
        send_request(FUNC_TOKEN, 2'd2, PID_DATA1_CODE, 7'd2, 4'd2, 11'd0);
        send_request(FUNC_DATA, 2'd2, 4'h0, 7'd0, 4'd0, 11'd0);
        // any other token code clears the toggle back to data0
        send_request(FUNC_DATA, 2'd1, 4'h0, 7'd0, 4'd0, 11'd0);
        send_request(FUNC_TOKEN, 2'd1, 4'h1, 7'd3, 4'd3, 11'd0);
        send_request(FUNC_DATA, 2'd1, 4'h0, 7'd0, 4'd0, 11'd0);
        // handshake takes any code as given, toggles untouched
        send_request(FUNC_HANDSHAKE, 2'd0, 4'h0, 7'd127, 4'd15, 11'd2047);
        send_request(FUNC_HANDSHAKE, 2'd3, 4'hF, 7'd0, 4'd0, 11'd0);
        send_request(FUNC_HANDSHAKE, 2'd1, 4'h2, 7'd0, 4'd0, 11'd0);
        send_request(FUNC_DATA, 2'd0, 4'h0, 7'd0, 4'd0, 11'd0);

        // random, in three idle phases
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 72;
                rx_idle_pct = 30;
            end else if (k == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random();
        end
        push <= 1'b0;

        // drain, then keep running for DRAIN_CYCLES to catch stray beats
        while (board.outstanding() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.outstanding() > 0) begin
            $display("%0d expected beats never came out", board.outstanding());
        end
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("usb_token_packet_builder_top_tb OK");
        end else begin
            $display("usb_token_packet_builder_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/utpb_pkg.sv
rtl/utpb_front.sv
rtl/utpb_queue.sv
rtl/utpb_back.sv
rtl/usb_token_packet_builder_top.sv
dv/usb_token_packet_builder_top_tb.sv
